// ===== rtl/pfl_pkg.sv =====
`default_nettype none

package pfl_pkg;

  // Default pool depth
  localparam int POOL_SIZE_DEF = 64;

  // Fixed field widths of the request and response words
  localparam int CMD_W   = 2;
  localparam int ENTRY_W = 6;

  // Command codes; the fourth code is unused and only returns an ungranted response
  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  // Request word
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ENTRY_W-1:0] entry;
  } req_t;

  // Response word
  typedef struct packed {
    logic               granted;
    logic [ENTRY_W-1:0] entry_out;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/pool_free_list_allocator.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Word
// req       in         req_valid / req_stall     req_t  {command, entry}
// rsp       out        rsp_valid / rsp_stall     rsp_t  {granted, entry_out}
//
// A granted allocate and an in-range free read the link memories on accept, then
// write in S_WR1 and S_WR2, since each needs two writes to the single write port
// of next_mem. Init sweeps next_mem one entry a cycle.
// After reset the same sweep runs with req_stall high.
// The response sits in an output register; a stalled response only holds the
// next item in its last cycle, a new request is taken once the work is done.

module pool_free_list_allocator
  import pfl_pkg::*;
#(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // Link width holds every index plus the sentinel value POOL_SIZE
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam int IW = $clog2(POOL_SIZE);
  localparam int CW = (LW > ENTRY_W) ? LW : ENTRY_W;

  localparam logic [LW-1:0] SENT     = LW'(POOL_SIZE);
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR1,
    S_WR2,
    S_SWEEP,
    S_FIN
  } state_t;

  state_t           state;
  logic [CMD_W-1:0] op;
  logic [IW-1:0]    node;
  logic [IW-1:0]    sweep_idx;
  logic             reply;
  logic             grant;
  logic [LW-1:0]    free_head;
  logic [LW-1:0]    used_first;
  logic [LW-1:0]    used_last;

  // Link memories
  logic [LW-1:0] next_mem [POOL_SIZE];
  logic [LW-1:0] prev_mem [POOL_SIZE];
  logic [LW-1:0] next_rd;
  logic [LW-1:0] prev_rd;

  logic          next_we;
  logic [IW-1:0] next_wa;
  logic [LW-1:0] next_wd;
  logic          prev_we;
  logic [IW-1:0] prev_wa;
  logic [LW-1:0] prev_wd;

  logic [CW-1:0] ent_w;
  logic          ent_ok;
  logic [IW-1:0] ent_idx;
  logic          head_ok;
  logic [IW-1:0] head_idx;
  logic          accept;
  logic [IW-1:0] rd_addr;
  logic          slot_free;
  logic          ul_ok;
  logic          nx_ok;
  logic          pv_ok;
  rsp_t          rsp_word;

  // Decode the request and the link values just read
  assign ent_w     = CW'(req.entry);
  assign ent_ok    = ent_w < CW'(POOL_SIZE);
  assign ent_idx   = ent_w[IW-1:0];
  assign head_ok   = free_head < SENT;
  assign head_idx  = free_head[IW-1:0];
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rd_addr   = (req.command == CMD_ALLOC) ? head_idx : ent_idx;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign ul_ok     = used_last < SENT;
  assign nx_ok     = next_rd < SENT;
  assign pv_ok     = prev_rd < SENT;

  assign rsp_word.granted   = grant;
  assign rsp_word.entry_out = grant ? ENTRY_W'(node) : '0;

  // Steer the single write port of each link memory
  always_comb begin
    next_we = 1'b0;
    next_wa = node;
    next_wd = SENT;
    prev_we = 1'b0;
    prev_wa = node;
    prev_wd = used_last;
    case (state)
      S_WR1: begin
        if (op == CMD_ALLOC) begin
          // new tail: back link to old tail, forward link ends the list
          next_we = 1'b1;
          prev_we = 1'b1;
        end else begin
          // bypass the freed entry in both directions
          next_we = pv_ok;
          next_wa = prev_rd[IW-1:0];
          next_wd = next_rd;
          prev_we = nx_ok;
          prev_wa = next_rd[IW-1:0];
          prev_wd = prev_rd;
        end
      end
      S_WR2: begin
        if (op == CMD_ALLOC) begin
          // link old tail forward to the new entry
          next_we = ul_ok;
          next_wa = used_last[IW-1:0];
          next_wd = LW'(node);
        end else begin
          // push the freed entry onto the free stack
          next_we = 1'b1;
          next_wd = free_head;
        end
      end
      S_SWEEP: begin
        next_we = 1'b1;
        next_wa = sweep_idx;
        next_wd = LW'(sweep_idx) + LW'(1);
      end
      default: begin
        next_we = 1'b0;
      end
    endcase
  end

  // Forward-link memory
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (accept) begin
      next_rd <= next_mem[rd_addr];
    end
  end

  // Back-link memory
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (accept) begin
      prev_rd <= prev_mem[rd_addr];
    end
  end

  // Sequence each command and hold the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_idx  <= '0;
      reply      <= 1'b0;
      grant      <= 1'b0;
      free_head  <= '0;
      used_first <= SENT;
      used_last  <= SENT;
      rsp_valid  <= 1'b0;
    end else begin
      // drop a taken word unless a new one loads this cycle
      if (rsp_valid && !rsp_stall && !(state inside {S_WR2, S_FIN})) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= req.command;
            grant <= (req.command == CMD_ALLOC) && head_ok;
            case (req.command)
              CMD_INIT: begin
                sweep_idx  <= '0;
                reply      <= 1'b1;
                free_head  <= '0;
                used_first <= SENT;
                used_last  <= SENT;
                state      <= S_SWEEP;
              end
              CMD_ALLOC: begin
                node <= head_idx;
                if (head_ok) begin
                  state <= S_WR1;
                end else begin
                  state <= S_FIN;
                end
              end
              CMD_FREE: begin
                node  <= ent_idx;
                state <= ent_ok ? S_WR1 : S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_WR1: begin
          if (op == CMD_ALLOC) begin
            free_head <= next_rd;
          end else begin
            if (!nx_ok) begin
              used_last <= prev_rd;
            end
            if (!pv_ok) begin
              used_first <= next_rd;
            end
          end
          state <= S_WR2;
        end
        S_WR2: begin
          if (op == CMD_ALLOC) begin
            if (!ul_ok) begin
              used_first <= LW'(node);
            end
            used_last <= LW'(node);
          end else begin
            free_head <= LW'(node);
          end
          if (slot_free) begin
            rsp_valid <= 1'b1;
            rsp       <= rsp_word;
            state     <= S_IDLE;
          end else begin
            state <= S_FIN;
          end
        end
        S_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == LAST_IDX) begin
            state <= reply ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            rsp_valid <= 1'b1;
            rsp       <= rsp_word;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfl_checker.sv =====
`default_nettype none

module pfl_checker
  import pfl_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire req_t req,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  // Hold a stalled request word
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request word changed");

  // Hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

  // Responses without a grant report entry zero
  a_zero_entry: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.granted |-> rsp.entry_out == '0)
    else $error("entry_out nonzero without grant");

  // Block requests while the pool is rebuilt after reset
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request taken during reset sweep");

  // Work on one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken back to back");

endmodule

bind pool_free_list_allocator pfl_checker u_pfl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
